@@ hdl/rarmt_pkg.sv @@
package rarmt_pkg;

  // Field widths fixed by the interface.
  localparam int POS_W = 11;
  localparam int AMT_W = 32;
  localparam int VAL_W = 64;

  // Frame stack: a tree over at most 2047 positions is at most 12 levels deep.
  localparam int STK_DEPTH = 16;
  localparam int STK_W     = 4;

  // Operation codes.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [VAL_W-1:0] value_t;

endpackage

@@ hdl/rarmt_ram.sv @@
module rarmt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/range_add_range_max_tree.sv @@
// Range-add / range-maximum store over signed 64-bit elements, kept as a segment
// tree with pending adds in one node memory of 4*MAX_ELEMENTS entries. A request
// walks the tree under a small sequencer with a frame stack: a fully covered node
// is read and then updated or compared (S_COV), a partly covered node pushes its
// pending add down to both children (S_PD0 to S_PD2) and, for an update,
// recomputes its maximum from both children on return (S_CMB0, S_CMB1), and a
// node outside the range is skipped. A request visits up to four nodes per level
// over log2(element_count) levels. in_stall is high for the whole walk, and a
// finished query also waits while an earlier result is still held by the
// receiver. After reset and after every write of element_count all
// 4*MAX_ELEMENTS entries of the memory are cleared, and no request is taken
// until the clearing is done.
module range_add_range_max_tree
  import rarmt_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [POS_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic [POS_W-1:0]        left,
  input  logic [POS_W-1:0]        right,
  input  logic signed [AMT_W-1:0] amount,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] range_max
);

  localparam int SLOTS  = 4 * MAX_ELEMENTS;
  localparam int NODE_W = $clog2(SLOTS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_VISIT = 4'd2;
  localparam logic [3:0] S_COV   = 4'd3;
  localparam logic [3:0] S_PD0   = 4'd4;
  localparam logic [3:0] S_PD1   = 4'd5;
  localparam logic [3:0] S_PD2   = 4'd6;
  localparam logic [3:0] S_RET   = 4'd7;
  localparam logic [3:0] S_CMB0  = 4'd8;
  localparam logic [3:0] S_CMB1  = 4'd9;

  logic [3:0]        state;
  pos_t              count;
  logic [NODE_W-1:0] clr_addr;
  logic [STK_W:0]    sp;
  logic [NODE_W-1:0] stk_node  [STK_DEPTH];
  pos_t              stk_lo    [STK_DEPTH];
  pos_t              stk_hi    [STK_DEPTH];
  logic              stk_phase [STK_DEPTH];
  logic [NODE_W-1:0] cur_node;
  pos_t              cur_lo;
  pos_t              cur_hi;
  logic              req_op;
  pos_t              req_l;
  pos_t              req_r;
  value_t            req_k;
  value_t            best;
  logic              best_valid;
  value_t            pend;
  value_t            cmb_a;

  logic                    ram_we;
  logic [NODE_W-1:0]       ram_waddr;
  logic [2*VAL_W-1:0]      ram_wdata;
  logic [NODE_W-1:0]       ram_raddr;
  logic [2*VAL_W-1:0]      ram_rdata;
  value_t                  rd_max;
  value_t                  rd_pend;
  logic [STK_W-1:0]        top;
  logic [NODE_W-1:0]       cur_child;
  logic [NODE_W-1:0]       top_child;
  pos_t                    cur_mid;
  pos_t                    top_mid;
  logic                    cur_out;
  logic                    cur_cov;
  value_t                  cmb_max;
  value_t                  cfg_fix;
  logic                    accept;
  logic                    res_load;

  rarmt_ram #(
    .WIDTH(2 * VAL_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Decoding of the current node, the top frame and the read data.
  assign rd_max    = ram_rdata[2*VAL_W-1:VAL_W];
  assign rd_pend   = ram_rdata[VAL_W-1:0];
  assign top       = STK_W'(sp - 1'b1);
  assign cur_child = {cur_node[NODE_W-2:0], 1'b0};
  assign top_child = {stk_node[top][NODE_W-2:0], 1'b0};
  assign cur_mid   = POS_W'(({1'b0, cur_lo} + {1'b0, cur_hi}) >> 1);
  assign top_mid   = POS_W'(({1'b0, stk_lo[top]} + {1'b0, stk_hi[top]}) >> 1);
  assign cur_out   = (cur_hi < req_l) || (cur_lo > req_r);
  assign cur_cov   = (req_l <= cur_lo) && (cur_hi <= req_r);
  assign cmb_max   = ($signed(cmb_a) > $signed(rd_max)) ? cmb_a : rd_max;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // A query result is loaded once the walk is back at the root and the
  // result register is free or being emptied.
  assign res_load  = (state == S_RET) && (sp == '0) && (req_op == OP_QUERY) &&
                     (!out_valid || !out_stall);

  // Clamp of a written element count to one through MAX_ELEMENTS.
  always_comb begin
    cfg_fix = VAL_W'(cfg_wdata);
    if (cfg_wdata == '0) begin
      cfg_fix = VAL_W'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_ELEMENTS)) begin
      cfg_fix = VAL_W'(MAX_ELEMENTS);
    end
  end

  // Node memory access for each sequencer step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_node;
    ram_wdata = '0;
    ram_raddr = cur_node;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_COV: begin
        ram_we    = (req_op == OP_ADD);
        ram_wdata = {rd_max + req_k, rd_pend + req_k};
      end
      S_PD0: begin
        ram_we    = 1'b1;
        ram_wdata = {rd_max, {VAL_W{1'b0}}};
        ram_raddr = cur_child;
      end
      S_PD1: begin
        ram_we    = 1'b1;
        ram_waddr = cur_child;
        ram_wdata = {rd_max + pend, rd_pend + pend};
        ram_raddr = cur_child | NODE_W'(1);
      end
      S_PD2: begin
        ram_we    = 1'b1;
        ram_waddr = cur_child | NODE_W'(1);
        ram_wdata = {rd_max + pend, rd_pend + pend};
      end
      S_RET: begin
        ram_raddr = top_child;
      end
      S_CMB0: begin
        ram_raddr = top_child | NODE_W'(1);
      end
      S_CMB1: begin
        ram_we    = 1'b1;
        ram_waddr = stk_node[top];
        ram_wdata = {cmb_max, {VAL_W{1'b0}}};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer: clearing sweep, tree walk with a frame stack, result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= POS_W'(MAX_ELEMENTS);
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      // Result register: loaded as a query ends, emptied once taken.
      if (res_load) begin
        out_valid <= 1'b1;
        range_max <= best_valid ? best : {VAL_W{1'b1}};
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        // A new element count empties the whole store.
        count    <= POS_W'(cfg_fix);
        clr_addr <= '0;
        state    <= S_CLEAR;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == NODE_W'(SLOTS - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              req_op     <= op;
              req_l      <= left;
              req_r      <= right;
              req_k      <= {{(VAL_W-AMT_W){amount[AMT_W-1]}}, amount};
              best_valid <= 1'b0;
              sp         <= '0;
              cur_node   <= NODE_W'(1);
              cur_lo     <= POS_W'(1);
              cur_hi     <= count;
              state      <= S_VISIT;
            end
          end
          S_VISIT: begin
            if (cur_out) begin
              state <= S_RET;
            end else if (cur_cov) begin
              state <= S_COV;
            end else begin
              state <= S_PD0;
            end
          end
          S_COV: begin
            if (req_op == OP_QUERY) begin
              best_valid <= 1'b1;
              if (!best_valid || ($signed(rd_max) > $signed(best))) begin
                best <= rd_max;
              end
            end
            state <= S_RET;
          end
          S_PD0: begin
            pend  <= rd_pend;
            state <= S_PD1;
          end
          S_PD1: begin
            state <= S_PD2;
          end
          S_PD2: begin
            // Save this node and descend into its left half.
            stk_node[sp[STK_W-1:0]]  <= cur_node;
            stk_lo[sp[STK_W-1:0]]    <= cur_lo;
            stk_hi[sp[STK_W-1:0]]    <= cur_hi;
            stk_phase[sp[STK_W-1:0]] <= 1'b0;
            sp       <= sp + 1'b1;
            cur_node <= cur_child;
            cur_hi   <= cur_mid;
            state    <= S_VISIT;
          end
          S_RET: begin
            if (sp == '0) begin
              if (req_op == OP_ADD) begin
                state <= S_IDLE;
              end else if (res_load) begin
                state <= S_IDLE;
              end
            end else if (!stk_phase[top]) begin
              stk_phase[top] <= 1'b1;
              cur_node       <= top_child | NODE_W'(1);
              cur_lo         <= top_mid + 1'b1;
              cur_hi         <= stk_hi[top];
              state          <= S_VISIT;
            end else if (req_op == OP_ADD) begin
              state <= S_CMB0;
            end else begin
              sp <= sp - 1'b1;
            end
          end
          S_CMB0: begin
            cmb_a <= rd_max;
            state <= S_CMB1;
          end
          S_CMB1: begin
            sp    <= sp - 1'b1;
            state <= S_RET;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule
